[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define FRLM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FRLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/frlm_pkg.sv]
`timescale 1ns / 1ps

package frlm_pkg;

  // field widths
  localparam int ADDR_W    = 24;
  localparam int DATA_W    = 64;
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 16;
  localparam int QTY_W     = 7;
  localparam int CMD_W     = 3;
  localparam int CNT_OUT_W = 17;

  // default geometry
  localparam int DEF_REGION_BYTES = 524288;
  localparam int DEF_RECORD_BYTES = 8;
  localparam int DEF_SECTOR_BYTES = 4096;

  localparam int MAX_DELETE = 64;

  localparam logic [ADDR_W-1:0] REGION_BASE_RST = 24'h102000;

  // request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  // flash command codes
  localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PROG    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MARKER  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ERASE   = 3'd4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_REF = 1'b1;

  // shared adder control
  typedef struct packed {
    logic sub;
    logic cin_force;
  } alu_ctl_t;

endpackage

[hw/rtl/flash_ring_log_manager.sv]
`timescale 1ns / 1ps

// Circular record log over one flash region. A request is taken on a clock
// edge with start high and busy low; each flash command it causes shows
// for exactly one cycle with result_valid_o high, and last_o marks the final
// beat of the request. The receiver cannot stall, so beats must be taken as
// they come. All address work runs through one shared adder under a small
// sequencer, one add or subtract per cycle. An append adds an erase beat
// when the new head opens a sector; a delete of n records gives n marker
// beats. A refused read or delete, a delete of zero and an unknown request
// answer in the cycle after acceptance without raising busy. SECTOR_BYTES
// is taken as a power of two. The user must write region_base through
// cfg_we_i / cfg_wdata_i only while the block idles; it is not enforced.

`include "assert_macros.svh"

module flash_ring_log_manager #(
  parameter int REGION_BYTES = frlm_pkg::DEF_REGION_BYTES,
  parameter int RECORD_BYTES = frlm_pkg::DEF_RECORD_BYTES,
  parameter int SECTOR_BYTES = frlm_pkg::DEF_SECTOR_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [frlm_pkg::ADDR_W-1:0]     cfg_wdata_i,
  // request
  input  logic                            start,
  output logic                            busy,
  input  logic [frlm_pkg::REQ_W-1:0]      req_type_i,
  input  logic [frlm_pkg::DATA_W-1:0]     record_value_i,
  input  logic [frlm_pkg::IDX_W-1:0]      record_index_i,
  input  logic [frlm_pkg::QTY_W-1:0]      delete_qty_i,
  // result
  output logic                            result_valid_o,
  output logic [frlm_pkg::CMD_W-1:0]      flash_cmd_o,
  output logic [frlm_pkg::ADDR_W-1:0]     flash_addr_o,
  output logic [frlm_pkg::DATA_W-1:0]     flash_data_o,
  output logic                            status_o,
  output logic [frlm_pkg::CNT_OUT_W-1:0]  stored_count_o,
  output logic                            last_o
);

  // log geometry
  localparam int LOG_SPAN = REGION_BYTES - (REGION_BYTES % RECORD_BYTES);
  localparam int LOG_CAP  = LOG_SPAN / RECORD_BYTES;
  localparam int OFF_W    = $clog2(LOG_SPAN);
  localparam int CNT_W    = $clog2(LOG_CAP + 1);
  localparam int SEC_SH   = $clog2(SECTOR_BYTES);
  localparam int PROD_W   = frlm_pkg::IDX_W + $clog2(RECORD_BYTES + 1);
  localparam int SUM_W    = ((frlm_pkg::ADDR_W > OFF_W + 1) ? frlm_pkg::ADDR_W : OFF_W + 1) + 1;
  localparam int CMP_W    = ((CNT_W > frlm_pkg::IDX_W) ? CNT_W : frlm_pkg::IDX_W) + 1;
  // span end, one bit wider than an offset
  localparam logic [OFF_W:0] SPAN_END = (OFF_W+1)'(LOG_SPAN);

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_A_HA    = 4'd1;  // head address
  localparam logic [3:0] ST_A_TA    = 4'd2;  // tail address, full check
  localparam logic [3:0] ST_A_ADV   = 4'd3;  // advance head
  localparam logic [3:0] ST_A_NA    = 4'd4;  // new head address, program beat
  localparam logic [3:0] ST_A_ERASE = 4'd5;  // erase beat
  localparam logic [3:0] ST_R_OFF   = 4'd6;  // tail plus index offset
  localparam logic [3:0] ST_R_WRAP  = 4'd7;  // wrap once
  localparam logic [3:0] ST_R_ADDR  = 4'd8;  // read beat
  localparam logic [3:0] ST_D_ADDR  = 4'd9;  // tail address
  localparam logic [3:0] ST_D_ADV   = 4'd10; // advance tail, marker beat

  logic [3:0]                      state_q, state_d;
  logic [frlm_pkg::ADDR_W-1:0]     base_q;
  logic [OFF_W-1:0]                head_q, head_d;
  logic [OFF_W-1:0]                tail_q, tail_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [frlm_pkg::DATA_W-1:0]     value_q, value_d;
  logic [PROD_W-1:0]               prod_q, prod_d;
  logic [SUM_W-1:0]                addr_q, addr_d;   // latched absolute address
  logic [OFF_W:0]                  off_q, off_d;     // read offset, before and after wrap
  logic [frlm_pkg::QTY_W-1:0]      rem_q, rem_d;

  // result beat registers
  logic                            valid_q, valid_d;
  logic [frlm_pkg::CMD_W-1:0]      cmd_q, cmd_d;
  logic [frlm_pkg::ADDR_W-1:0]     oaddr_q, oaddr_d;
  logic [frlm_pkg::DATA_W-1:0]     odata_q, odata_d;
  logic                            ostat_q, ostat_d;
  logic [CNT_W-1:0]                ocnt_q, ocnt_d;
  logic                            olast_q, olast_d;

  // shared adder
  logic [SUM_W-1:0]                alu_a, alu_b, alu_res;
  frlm_pkg::alu_ctl_t              alu_ctl;
  logic                            alu_carry;

  logic                            accept;
  logic [CNT_W-1:0]                count_dec;
  logic [OFF_W-1:0]                adv_off;
  logic                            offs_ok;

  frlm_alu #(
    .WIDTH (SUM_W)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .ctl_i   (alu_ctl),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign count_dec = count_q - CNT_W'(1);
  // wrapped head or tail after adding one record
  assign adv_off   = (alu_res >= SUM_W'(LOG_SPAN)) ? '0 : alu_res[OFF_W-1:0];

  // operand selection for the shared adder
  always_comb begin
    alu_a = SUM_W'(base_q);
    alu_b = SUM_W'(head_q);
    alu_ctl = '{sub: 1'b0, cin_force: 1'b0};
    case (state_q)
      ST_A_HA: begin
        alu_b = SUM_W'(head_q);
      end
      ST_A_TA, ST_D_ADDR: begin
        alu_b = SUM_W'(tail_q);
      end
      ST_A_ADV: begin
        alu_a = SUM_W'(head_q);
        alu_b = SUM_W'(RECORD_BYTES);
      end
      ST_A_NA: begin
        alu_b = SUM_W'(head_q);
      end
      ST_R_OFF: begin
        alu_a = SUM_W'(tail_q);
        alu_b = SUM_W'(prod_q);
      end
      ST_R_WRAP: begin
        alu_a   = SUM_W'(off_q);
        alu_b   = SUM_W'(LOG_SPAN);
        alu_ctl = '{sub: 1'b1, cin_force: 1'b0};
      end
      ST_R_ADDR: begin
        alu_b = SUM_W'(off_q);
      end
      ST_D_ADV: begin
        alu_a = SUM_W'(tail_q);
        alu_b = SUM_W'(RECORD_BYTES);
      end
      default: begin
        alu_b = SUM_W'(head_q);
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    value_d = value_q;
    prod_d  = prod_q;
    addr_d  = addr_q;
    off_d   = off_q;
    rem_d   = rem_q;
    valid_d = 1'b0;
    cmd_d   = cmd_q;
    oaddr_d = oaddr_q;
    odata_d = odata_q;
    ostat_d = ostat_q;
    ocnt_d  = ocnt_q;
    olast_d = olast_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // default beat: refused, nothing issued
          cmd_d   = frlm_pkg::CMD_NONE;
          oaddr_d = '0;
          odata_d = '0;
          ostat_d = frlm_pkg::STATUS_REF;
          ocnt_d  = count_q;
          olast_d = 1'b1;
          case (req_type_i)
            frlm_pkg::REQ_APPEND: begin
              value_d = record_value_i;
              state_d = ST_A_HA;
            end
            frlm_pkg::REQ_READ: begin
              if (CMP_W'(record_index_i) >= CMP_W'(count_q)) begin
                valid_d = 1'b1;
              end else begin
                prod_d  = PROD_W'(record_index_i) * PROD_W'(RECORD_BYTES);
                state_d = ST_R_OFF;
              end
            end
            frlm_pkg::REQ_DELETE: begin
              if ((CMP_W'(delete_qty_i) > CMP_W'(count_q)) ||
                  (delete_qty_i > frlm_pkg::QTY_W'(frlm_pkg::MAX_DELETE))) begin
                valid_d = 1'b1;
              end else if (delete_qty_i == '0) begin
                // nothing to remove, accepted
                valid_d = 1'b1;
                ostat_d = frlm_pkg::STATUS_OK;
              end else begin
                rem_d   = delete_qty_i;
                state_d = ST_D_ADDR;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_A_HA: begin
        addr_d  = alu_res;
        state_d = ST_A_ADV - 4'd1;
      end

      ST_A_TA: begin
        // full: same sector and head behind tail
        if ((addr_q[SUM_W-1:SEC_SH] == alu_res[SUM_W-1:SEC_SH]) && (head_q < tail_q)) begin
          valid_d = 1'b1;
          cmd_d   = frlm_pkg::CMD_NONE;
          oaddr_d = '0;
          odata_d = '0;
          ostat_d = frlm_pkg::STATUS_REF;
          ocnt_d  = count_q;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_A_ADV;
        end
      end

      ST_A_ADV: begin
        head_d = adv_off;
        if (count_q < CNT_W'(LOG_CAP)) begin
          count_d = count_q + CNT_W'(1);
        end
        state_d = ST_A_NA;
      end

      ST_A_NA: begin
        valid_d = 1'b1;
        cmd_d   = frlm_pkg::CMD_PROG;
        oaddr_d = addr_q[frlm_pkg::ADDR_W-1:0];
        odata_d = value_q;
        ostat_d = frlm_pkg::STATUS_OK;
        ocnt_d  = count_q;
        if (alu_res[SEC_SH-1:0] == '0) begin
          // new head opens a sector: erase it next
          olast_d = 1'b0;
          addr_d  = alu_res;
          state_d = ST_A_ERASE;
        end else begin
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_A_ERASE: begin
        valid_d = 1'b1;
        cmd_d   = frlm_pkg::CMD_ERASE;
        oaddr_d = addr_q[frlm_pkg::ADDR_W-1:0];
        odata_d = '0;
        ostat_d = frlm_pkg::STATUS_OK;
        ocnt_d  = count_q;
        olast_d = 1'b1;
        state_d = ST_IDLE;
      end

      ST_R_OFF: begin
        off_d   = alu_res[OFF_W:0];
        state_d = ST_R_WRAP;
      end

      ST_R_WRAP: begin
        // no borrow: offset ran past the span
        if (alu_carry) begin
          off_d = alu_res[OFF_W:0];
        end
        state_d = ST_R_ADDR;
      end

      ST_R_ADDR: begin
        valid_d = 1'b1;
        cmd_d   = frlm_pkg::CMD_READ;
        oaddr_d = alu_res[frlm_pkg::ADDR_W-1:0];
        odata_d = '0;
        ostat_d = frlm_pkg::STATUS_OK;
        ocnt_d  = count_q;
        olast_d = 1'b1;
        state_d = ST_IDLE;
      end

      ST_D_ADDR: begin
        addr_d  = alu_res;
        state_d = ST_D_ADV;
      end

      ST_D_ADV: begin
        tail_d  = adv_off;
        count_d = count_dec;
        rem_d   = rem_q - frlm_pkg::QTY_W'(1);
        valid_d = 1'b1;
        cmd_d   = frlm_pkg::CMD_MARKER;
        oaddr_d = addr_q[frlm_pkg::ADDR_W-1:0];
        odata_d = '0;
        ostat_d = frlm_pkg::STATUS_OK;
        ocnt_d  = count_dec;
        olast_d = (rem_q == frlm_pkg::QTY_W'(1));
        state_d = (rem_q == frlm_pkg::QTY_W'(1)) ? ST_IDLE : ST_D_ADDR;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      base_q  <= frlm_pkg::REGION_BASE_RST;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      rem_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prod_q  <= prod_d;
    addr_q  <= addr_d;
    off_q   <= off_d;
    cmd_q   <= cmd_d;
    oaddr_q <= oaddr_d;
    odata_q <= odata_d;
    ostat_q <= ostat_d;
    ocnt_q  <= ocnt_d;
    olast_q <= olast_d;
  end

  assign result_valid_o = valid_q;
  assign flash_cmd_o    = cmd_q;
  assign flash_addr_o   = oaddr_q;
  assign flash_data_o   = odata_q;
  assign status_o       = ostat_q;
  assign stored_count_o = frlm_pkg::CNT_OUT_W'(ocnt_q);
  assign last_o         = olast_q;

  // both offsets inside the span
  assign offs_ok = ((OFF_W+1)'(head_q) < SPAN_END) && ((OFF_W+1)'(tail_q) < SPAN_END);

  // checks
  `FRLM_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |-> !busy, "busy during reset")
  `FRLM_ASSERT(a_offsets_in_span, clk_i, rst_ni, offs_ok, "offset past log span")
  `FRLM_ASSERT(a_count_in_cap, clk_i, rst_ni, count_q <= CNT_W'(LOG_CAP), "count above capacity")
  `FRLM_ASSERT(a_more_beats, clk_i, rst_ni, result_valid_o && !last_o |-> busy, "beat ended request")
  `FRLM_ASSERT(a_none_no_addr, clk_i, rst_ni, result_valid_o && (flash_cmd_o == frlm_pkg::CMD_NONE) |-> (flash_addr_o == '0), "address on empty beat")

endmodule

[hw/rtl/frlm_alu.sv]
`timescale 1ns / 1ps

module frlm_alu #(
  parameter int WIDTH = 26
) (
  input  logic [WIDTH-1:0]      a_i,
  input  logic [WIDTH-1:0]      b_i,
  input  frlm_pkg::alu_ctl_t    ctl_i,
  output logic [WIDTH-1:0]      res_o,
  output logic                  carry_o
);

  logic [WIDTH-1:0] b_op;
  logic             cin;
  logic [WIDTH:0]   full;

  // subtract as a + ~b + 1, carry out set means no borrow
  assign b_op = ctl_i.sub ? ~b_i : b_i;
  assign cin  = ctl_i.sub | ctl_i.cin_force;
  assign full = {1'b0, a_i} + {1'b0, b_op} + {{WIDTH{1'b0}}, cin};

  assign res_o   = full[WIDTH-1:0];
  assign carry_o = full[WIDTH];

endmodule
